@@ hw/rtl/kse_pkg.sv @@
// ============================================================================
// kse_pkg : shared types and constants of the key sort engine
// Controller states, the control word that goes to every cell, register
// indexes and default sizes.
// ============================================================================
package kse_pkg;

    // width of the key and sorted_key ports
    localparam int FIELD_W         = 32;

    // defaults for the top-level parameters
    localparam int DEPTH_DEF       = 64;
    localparam int KEY_WIDTH_DEF   = 32;

    // configuration register indexes
    localparam logic REG_DESCENDING = 1'b0;
    localparam logic REG_SIGNED     = 1'b1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_OUT
    } kse_state_t;

    // control word broadcast along the cell chain
    typedef struct packed {
        logic load;     // cell at the fill position takes the incoming key
        logic sort_en;  // compare-exchange pass in progress
        logic phase;    // 0: pairs start at even cells, 1: at odd cells
        logic shift;    // move every key one cell towards the head
        logic desc;     // descending order
        logic sgn;      // two's complement keys
    } kse_ctrl_t;

endpackage

@@ hw/rtl/kse_cell.sv @@
// ============================================================================
// kse_cell : one cell of the sorting chain
// Holds one key. Loads at its own fill position, compare-exchanges with one
// neighbour per sort pass, and takes its right neighbour's key on a shift.
// ============================================================================
module kse_cell
    import kse_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    parameter int INDEX     = 0,
    localparam int CNT_W    = $clog2(DEPTH + 1)
)
(
    input  logic                 clk,
    input  kse_ctrl_t            ctrl,
    input  logic [CNT_W-1:0]     count,
    input  logic [KEY_WIDTH-1:0] key_in,
    input  logic [KEY_WIDTH-1:0] left_key,
    input  logic [KEY_WIDTH-1:0] right_key,
    output logic [KEY_WIDTH-1:0] key_q
);

    localparam logic [KEY_WIDTH-1:0] SIGN_MASK = KEY_WIDTH'(1) << (KEY_WIDTH - 1);
    localparam logic IDX_ODD  = ((INDEX % 2) == 1);
    localparam logic HAS_LEFT = (INDEX > 0);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic [KEY_WIDTH-1:0] own_ord;
    logic [KEY_WIDTH-1:0] left_ord;
    logic [KEY_WIDTH-1:0] right_ord;
    logic                 is_left;
    logic                 left_role_ok;
    logic                 right_role_ok;

    // maps a key so that plain unsigned order is the output order
    function automatic logic [KEY_WIDTH-1:0] ord_val(
        input logic [KEY_WIDTH-1:0] k,
        input logic                 desc,
        input logic                 sgn
    );
        ord_val = k ^ ({KEY_WIDTH{sgn}} & SIGN_MASK) ^ {KEY_WIDTH{desc}};
    endfunction

    assign own_ord   = ord_val(key_reg,   ctrl.desc, ctrl.sgn);
    assign left_ord  = ord_val(left_key,  ctrl.desc, ctrl.sgn);
    assign right_ord = ord_val(right_key, ctrl.desc, ctrl.sgn);

    assign is_left       = (ctrl.phase == IDX_ODD);
    // both cells of a pair must lie inside the run
    assign left_role_ok  = (count > CNT_W'(INDEX + 1));
    assign right_role_ok = HAS_LEFT && (count > CNT_W'(INDEX));

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.load && (count == CNT_W'(INDEX)))
        begin
            key_next = key_in;
        end
        else if (ctrl.sort_en)
        begin
            if (is_left)
            begin
                if (left_role_ok && (own_ord > right_ord))
                begin
                    key_next = right_key;
                end
            end
            else
            begin
                if (right_role_ok && (left_ord > own_ord))
                begin
                    key_next = left_key;
                end
            end
        end
        else if (ctrl.shift)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key_q = key_reg;

endmodule

@@ hw/rtl/kse_ctrl.sv @@
// ============================================================================
// kse_ctrl : sequencer of the key sort engine
// Tracks fill count and overflow, runs the sort passes, counts out results
// and holds the two configuration registers.
// ============================================================================
module kse_ctrl
    import kse_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             last,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             end_of_run,
    output logic             dropped,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic             cfg_data,
    output kse_ctrl_t        ctrl,
    output logic [CNT_W-1:0] count
);

    localparam int PASS_W = $clog2(DEPTH);

    kse_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PASS_W-1:0] pass_reg,  pass_next;
    logic              drop_reg,  drop_next;
    logic              desc_reg,  desc_next;
    logic              sgn_reg,   sgn_next;
    logic              in_acc;
    logic              out_acc;
    logic              full;
    logic              last_pass;

    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign last_pass = (pass_reg == PASS_W'(DEPTH - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && last)
                begin
                    state_next = ST_SORT;
                end
            end
            ST_SORT:
            begin
                if (last_pass)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_acc && (count_reg == CNT_W'(1)))
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // counters and flags
    always_comb
    begin
        count_next = count_reg;
        pass_next  = pass_reg;
        drop_next  = drop_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                pass_next = '0;
                if (in_acc)
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_SORT:
            begin
                pass_next = pass_reg + PASS_W'(1);
            end
            ST_OUT:
            begin
                if (out_acc)
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        drop_next = 1'b0;
                    end
                end
            end
            default:
            begin
                count_next = '0;
                drop_next  = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_comb
    begin
        desc_next = desc_reg;
        sgn_next  = sgn_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DESCENDING: desc_next = cfg_data;
                REG_SIGNED:     sgn_next  = cfg_data;
                default:        desc_next = desc_reg;
            endcase
        end
    end

    // outputs
    always_comb
    begin
        in_stall     = 1'b1;
        out_valid    = 1'b0;
        ctrl.load    = 1'b0;
        ctrl.sort_en = 1'b0;
        ctrl.shift   = 1'b0;
        ctrl.phase   = pass_reg[0];
        ctrl.desc    = desc_reg;
        ctrl.sgn     = sgn_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_stall  = 1'b0;
                ctrl.load = in_valid && !full;
            end
            ST_SORT:
            begin
                ctrl.sort_en = 1'b1;
            end
            ST_OUT:
            begin
                out_valid  = 1'b1;
                ctrl.shift = out_acc;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign count      = count_reg;
    assign end_of_run = (count_reg == CNT_W'(1));
    assign dropped    = drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            pass_reg  <= '0;
            drop_reg  <= 1'b0;
            desc_reg  <= 1'b0;
            sgn_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pass_reg  <= pass_next;
            drop_reg  <= drop_next;
            desc_reg  <= desc_next;
            sgn_reg   <= sgn_next;
        end
    end

endmodule

@@ hw/rtl/key_sort_engine_top.sv @@
// ============================================================================
// key_sort_engine_top : run sorter built from a chain of key cells
// Collects a run of keys, sorts them by odd-even transposition along the
// chain, then streams them out in order with the final one marked.
// ============================================================================
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------
//  input    | in_valid / in_stall  | key[31:0], last
//  output   | out_valid / out_stall| sorted_key[31:0], end_of_run, dropped
//  config   | cfg_we               | cfg_index, cfg_data (no read-back)
//
//  Flow   : a run of n items is taken one item per cycle, then DEPTH
//           compare-exchange passes run, then results leave one per cycle while
//           out_stall is low. The sort pass count sets the gap between runs.
//  Input  : in_stall is high from the item marked last until the final
//           result of that run has been taken.
//  Stalls : out_stall freezes the chain; the head cell holds the result.
//  Reset  : rst_n is asynchronous; it clears the sequencer, the fill count
//           and the registers. Cells carry no reset and need no clearing.
//
module key_sort_engine_top
    import kse_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,     // 2 .. 64
    parameter int KEY_WIDTH = KEY_WIDTH_DEF  // 1 .. 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input items
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [FIELD_W-1:0] key,
    input  logic               last,
    // result items
    output logic               out_valid,
    input  logic               out_stall,
    output logic [FIELD_W-1:0] sorted_key,
    output logic               end_of_run,
    output logic               dropped,
    // configuration
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic               cfg_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    kse_ctrl_t            ctrl;
    logic [CNT_W-1:0]     count;
    logic [KEY_WIDTH-1:0] key_in;
    logic [KEY_WIDTH-1:0] cell_key [DEPTH];

    // key port to internal width: keep the low bits, or zero-extend
    generate
        if (KEY_WIDTH <= FIELD_W)
        begin : g_in_narrow
            assign key_in = key[KEY_WIDTH-1:0];
        end
        else
        begin : g_in_wide
            assign key_in = {{(KEY_WIDTH - FIELD_W){1'b0}}, key};
        end
    endgenerate

    kse_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .last       (last),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .end_of_run (end_of_run),
        .dropped    (dropped),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .ctrl       (ctrl),
        .count      (count)
    );

    // the chain: cell 0 is the head and drives the result
    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [KEY_WIDTH-1:0] left_k;
            logic [KEY_WIDTH-1:0] right_k;

            if (i == 0)
            begin : g_head
                assign left_k = cell_key[i];
            end
            else
            begin : g_mid_l
                assign left_k = cell_key[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign right_k = cell_key[i];
            end
            else
            begin : g_mid_r
                assign right_k = cell_key[i+1];
            end

            kse_cell #(
                .DEPTH     (DEPTH),
                .KEY_WIDTH (KEY_WIDTH),
                .INDEX     (i)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .count     (count),
                .key_in    (key_in),
                .left_key  (left_k),
                .right_key (right_k),
                .key_q     (cell_key[i])
            );
        end
    endgenerate

    // head cell back to port width
    generate
        if (KEY_WIDTH >= FIELD_W)
        begin : g_out_narrow
            assign sorted_key = cell_key[0][FIELD_W-1:0];
        end
        else
        begin : g_out_wide
            assign sorted_key = {{(FIELD_W - KEY_WIDTH){1'b0}}, cell_key[0]};
        end
    endgenerate

endmodule

@@ hw/rtl/kse_checker.sv @@
// ============================================================================
// kse_checker : port-level checks of the key sort engine
// Watches the top-level ports only; attached by the bind below.
// ============================================================================
module kse_checker
    import kse_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               last,
    input logic               out_valid,
    input logic               out_stall,
    input logic [FIELD_W-1:0] sorted_key,
    input logic               end_of_run,
    input logic               dropped
);

    // no new item while results are pending
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while results pending");

    // the item marked last closes the input until the run is out
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last) |=> in_stall)
        else $error("input open after last item");

    // final result ends the output burst
    a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && end_of_run) |=> !out_valid)
        else $error("result after end of run");

    // dropped flag is one value across a run
    a_drop_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && $past(out_valid)) |-> (dropped == $past(dropped)))
        else $error("dropped flag changed inside run");

    // stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(sorted_key)))
        else $error("stalled result changed");

endmodule

bind key_sort_engine_top kse_checker u_kse_checker (.*);
